[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NCLM_AST_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nclm check failed");

// next-cycle implication
`define NCLM_AST_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nclm check failed");

`endif

[src/nclm_pkg.sv]
// ----------------------------------------------------------------------------
// nclm_pkg
// sizes, codes and state type of the nearest-centre label map
// ----------------------------------------------------------------------------
package nclm_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int MAX_CENTERS = 1024;

  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int YW        = $clog2(MAX_HEIGHT);
  localparam int MAP_AW    = XW + YW;
  localparam int MAP_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int CW        = $clog2(MAX_CENTERS);

  localparam int LABEL_W = 11;
  localparam int DIST_W  = 16;
  localparam int MAP_DW  = LABEL_W + DIST_W;
  localparam int CNT_W   = 16;

  localparam logic [LABEL_W-1:0] NO_LABEL = '1;
  localparam logic [DIST_W-1:0]  FAR_DIST = '1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_STAMP = 2'd1,
    OP_START = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_RADIUS = 2'd2,
    CFG_ONE2ONE = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_CSWEEP,
    ST_SETUP,
    ST_STAMP,
    ST_DRAIN,
    ST_Q_LBL,
    ST_Q_CLM
  } state_t;

endpackage

[src/nclm_ram.sv]
// ----------------------------------------------------------------------------
// nclm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module nclm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/nearest_center_label_map_inliers.sv]
// ----------------------------------------------------------------------------
// nearest_center_label_map_inliers
// per-pixel label map with best squared distance, centre stamping and
// projection queries with inlier counting
// ----------------------------------------------------------------------------
// stamp: R = ceil(radius_q4/16), walks the square of half-side R, one pixel per cycle
//   through the map ram read-compare-write pipe; a refused stamp skips the walk
// query: reads the label, then in one-to-one mode the claim ram when the pixel holds a label
// start query set: claim ram sweep; clear: map sweep
// reset: synchronous, then a map and claim sweep with busy high
// result strobe out_valid lasts one cycle, in the same cycle that busy drops
module nearest_center_label_map_inliers import nclm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_opcode,
  input  logic signed [15:0]        in_x_q4,
  input  logic signed [15:0]        in_y_q4,
  // result channel
  output logic                      out_valid,
  output logic                      out_hit,
  output logic signed [LABEL_W-1:0] out_label,
  output logic [CNT_W-1:0]          out_item_index,
  output logic [CNT_W-1:0]          out_inlier_count,
  output logic                      out_overflow,
  // configuration channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [11:0]               cfg_data
);

  // half-away-from-zero rounding of a q4 value to whole pixels
  function automatic logic signed [13:0] round_q4(input logic signed [15:0] v);
    logic [16:0] mag;
    logic [16:0] q;
    mag = v[15] ? 17'(-$signed({v[15], v})) : {1'b0, v};
    q   = (mag + 17'd8) >> 4;
    return v[15] ? -$signed(14'(q)) : $signed(14'(q));
  endfunction

  // truncation toward zero
  function automatic logic signed [13:0] trunc_q4(input logic signed [15:0] v);
    logic [16:0] mag;
    logic [16:0] q;
    mag = v[15] ? 17'(-$signed({v[15], v})) : {1'b0, v};
    q   = mag >> 4;
    return v[15] ? -$signed(14'(q)) : $signed(14'(q));
  endfunction

  // ---------------------------------------------------------------- registers
  state_t               state_r, state_nxt;
  logic [10:0]          width_r, height_r;
  logic [11:0]          radius_r;
  logic                 o2o_r;

  logic [CW:0]          ctr_cnt_r, ctr_cnt_nxt;
  logic [CNT_W-1:0]     proj_cnt_r, proj_cnt_nxt;
  logic [CNT_W-1:0]     inl_cnt_r, inl_cnt_nxt;
  logic [MAP_AW-1:0]    sweep_r, sweep_nxt;

  // stamp walk
  logic signed [13:0]   cx_r, cx_nxt, cy_r, cy_nxt;
  logic [8:0]           range_r, range_nxt;
  logic [23:0]          r2_r, r2_nxt;
  logic signed [9:0]    dx_r, dx_nxt, dy_r, dy_nxt;
  logic [16:0]          dy2_r, dy2_nxt;

  // read-compare-write stage of the walk
  logic                 s1_vld_r, s1_vld_nxt;
  logic [MAP_AW-1:0]    s1_addr_r, s1_addr_nxt;
  logic [DIST_W-1:0]    s1_d2_r, s1_d2_nxt;

  // query
  logic                 q_in_r, q_in_nxt;
  logic [LABEL_W-1:0]   q_label_r, q_label_nxt;
  logic [CNT_W-1:0]     item_r, item_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic [LABEL_W-1:0]   out_label_r, out_label_nxt;
  logic [CNT_W-1:0]     out_item_r, out_item_nxt;
  logic [CNT_W-1:0]     out_inl_r, out_inl_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  // ---------------------------------------------------------------- rams
  logic                 map_we;
  logic [MAP_AW-1:0]    map_waddr, map_raddr;
  logic [MAP_DW-1:0]    map_wdata, map_rdata;
  logic                 claim_we;
  logic [CW-1:0]        claim_waddr, claim_raddr;
  logic [0:0]           claim_wdata, claim_rdata;

  nclm_ram #(.WIDTH(MAP_DW), .DEPTH(MAP_DEPTH)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  nclm_ram #(.WIDTH(1), .DEPTH(MAX_CENTERS)) u_claim_ram (
    .clk   (clk),
    .we    (claim_we),
    .waddr (claim_waddr),
    .wdata (claim_wdata),
    .raddr (claim_raddr),
    .rdata (claim_rdata)
  );

  // ---------------------------------------------------------------- datapath
  logic                 accept;
  logic [10:0]          act_w, act_h;
  logic signed [13:0]   cx_in, cy_in, px_in, py_in;
  logic                 q_in_img;
  logic [MAP_AW-1:0]    q_addr;

  logic signed [19:0]   dx_sq;
  logic [17:0]          d2;
  logic                 in_disk;
  logic signed [13:0]   sx, sy;
  logic                 s_in_img;
  logic [MAP_AW-1:0]    s_addr;
  logic signed [9:0]    range_s, dy_inc;
  logic signed [19:0]   dy_inc_sq;
  logic [17:0]          range_sq;
  logic                 last_x, last_y;
  logic [LABEL_W-1:0]   rd_label;
  logic [CNT_W-1:0]     inl_inc;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // sizes above the map saturate to it
  assign act_w = (width_r  > 11'(MAX_WIDTH))  ? 11'(MAX_WIDTH)  : width_r;
  assign act_h = (height_r > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : height_r;

  assign cx_in = round_q4(in_x_q4);
  assign cy_in = round_q4(in_y_q4);
  assign px_in = trunc_q4(in_x_q4);
  assign py_in = trunc_q4(in_y_q4);
  assign q_in_img = (px_in >= 0) && (px_in < $signed({3'b000, act_w}))
                 && (py_in >= 0) && (py_in < $signed({3'b000, act_h}));
  assign q_addr = {py_in[YW-1:0], px_in[XW-1:0]};

  // disk membership and clipping of the current walk pixel
  assign dx_sq   = dx_r * dx_r;
  assign d2      = {1'b0, dx_sq[16:0]} + {1'b0, dy2_r};
  assign in_disk = ({d2, 8'd0} <= {2'b00, r2_r});
  assign sx      = cx_r + 14'(dx_r);
  assign sy      = cy_r + 14'(dy_r);
  assign s_in_img = (sx >= 0) && (sx < $signed({3'b000, act_w}))
                 && (sy >= 0) && (sy < $signed({3'b000, act_h}));
  assign s_addr  = {sy[YW-1:0], sx[XW-1:0]};

  assign range_s   = $signed({1'b0, range_r});
  assign range_sq  = range_r * range_r;
  assign dy_inc    = dy_r + 10'sd1;
  assign dy_inc_sq = dy_inc * dy_inc;
  assign last_x    = (dx_r == range_s);
  assign last_y    = (dy_r == range_s);

  assign rd_label = map_rdata[MAP_DW-1:DIST_W];
  assign inl_inc  = (inl_cnt_r == '1) ? inl_cnt_r : inl_cnt_r + 1'b1;

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt    = state_r;
    ctr_cnt_nxt  = ctr_cnt_r;
    proj_cnt_nxt = proj_cnt_r;
    inl_cnt_nxt  = inl_cnt_r;
    sweep_nxt    = sweep_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    range_nxt    = range_r;
    r2_nxt       = r2_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    dy2_nxt      = dy2_r;
    s1_vld_nxt   = 1'b0;
    s1_addr_nxt  = s_addr;
    s1_d2_nxt    = d2[DIST_W-1:0];
    q_in_nxt     = q_in_r;
    q_label_nxt  = q_label_r;
    item_nxt     = item_r;

    out_valid_nxt = 1'b0;
    out_hit_nxt   = 1'b0;
    out_label_nxt = out_label_r;
    out_item_nxt  = out_item_r;
    out_inl_nxt   = out_inl_r;
    out_ovf_nxt   = 1'b0;

    // closer centre takes the pixel, ties keep the earlier one
    map_we    = s1_vld_r && (s1_d2_r < map_rdata[DIST_W-1:0]);
    map_waddr = s1_addr_r;
    map_wdata = {LABEL_W'(ctr_cnt_r[CW-1:0]), s1_d2_r};
    map_raddr = s_addr;

    claim_we    = 1'b0;
    claim_waddr = sweep_r[CW-1:0];
    claim_wdata = 1'b0;
    claim_raddr = rd_label[CW-1:0];

    case (state_r)
      ST_INIT: begin
        map_we    = 1'b1;
        map_waddr = sweep_r;
        map_wdata = {NO_LABEL, FAR_DIST};
        claim_we  = (sweep_r[MAP_AW-1:CW] == '0);
        sweep_nxt = sweep_r + 1'b1;
        if (&sweep_r) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          case (op_t'(in_opcode))
            OP_CLEAR: begin
              sweep_nxt = '0;
              state_nxt = ST_CLEAR;
            end
            OP_STAMP: begin
              cx_nxt    = cx_in;
              cy_nxt    = cy_in;
              range_nxt = 9'((13'(radius_r) + 13'd15) >> 4);
              r2_nxt    = radius_r * radius_r;
              state_nxt = (ctr_cnt_r >= (CW+1)'(MAX_CENTERS)) ? ST_DRAIN : ST_SETUP;
            end
            OP_START: begin
              sweep_nxt    = '0;
              proj_cnt_nxt = '0;
              inl_cnt_nxt  = '0;
              state_nxt    = ST_CSWEEP;
            end
            OP_QUERY: begin
              map_raddr    = q_addr;
              q_in_nxt     = q_in_img;
              item_nxt     = proj_cnt_r;
              proj_cnt_nxt = proj_cnt_r + 1'b1;
              state_nxt    = ST_Q_LBL;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = sweep_r;
        map_wdata = {NO_LABEL, FAR_DIST};
        sweep_nxt = sweep_r + 1'b1;
        if (&sweep_r) begin
          ctr_cnt_nxt   = '0;
          out_valid_nxt = 1'b1;
          out_label_nxt = NO_LABEL;
          out_item_nxt  = '0;
          out_inl_nxt   = inl_cnt_r;
          state_nxt     = ST_IDLE;
        end
      end

      ST_CSWEEP: begin
        claim_we  = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        if (&sweep_r[CW-1:0]) begin
          out_valid_nxt = 1'b1;
          out_label_nxt = NO_LABEL;
          out_item_nxt  = '0;
          out_inl_nxt   = inl_cnt_r;
          state_nxt     = ST_IDLE;
        end
      end

      ST_SETUP: begin
        dx_nxt    = -range_s;
        dy_nxt    = -range_s;
        dy2_nxt   = range_sq[16:0];
        state_nxt = ST_STAMP;
      end

      ST_STAMP: begin
        s1_vld_nxt = in_disk && s_in_img;
        if (last_x) begin
          dx_nxt  = -range_s;
          dy_nxt  = dy_inc;
          dy2_nxt = dy_inc_sq[16:0];
          if (last_y) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          dx_nxt = dx_r + 10'sd1;
        end
      end

      ST_DRAIN: begin
        // last pixel of the walk is written back this cycle
        out_valid_nxt = 1'b1;
        out_item_nxt  = CNT_W'(ctr_cnt_r);
        out_inl_nxt   = inl_cnt_r;
        if (ctr_cnt_r >= (CW+1)'(MAX_CENTERS)) begin
          out_ovf_nxt   = 1'b1;
          out_label_nxt = NO_LABEL;
        end else begin
          out_label_nxt = LABEL_W'(ctr_cnt_r[CW-1:0]);
          ctr_cnt_nxt   = ctr_cnt_r + 1'b1;
        end
        state_nxt = ST_IDLE;
      end

      ST_Q_LBL: begin
        q_label_nxt  = q_in_r ? rd_label : NO_LABEL;
        out_label_nxt = q_label_nxt;
        out_item_nxt  = item_r;
        if (q_in_r && !rd_label[LABEL_W-1] && o2o_r) begin
          state_nxt = ST_Q_CLM;
        end else begin
          out_valid_nxt = 1'b1;
          if (q_in_r && !rd_label[LABEL_W-1]) begin
            out_hit_nxt = 1'b1;
            inl_cnt_nxt = inl_inc;
          end
          out_inl_nxt = inl_cnt_nxt;
          state_nxt   = ST_IDLE;
        end
      end

      ST_Q_CLM: begin
        out_valid_nxt = 1'b1;
        out_label_nxt = q_label_r;
        out_item_nxt  = item_r;
        claim_waddr   = q_label_r[CW-1:0];
        claim_wdata   = 1'b1;
        if (!claim_rdata[0]) begin
          claim_we    = 1'b1;
          out_hit_nxt = 1'b1;
          inl_cnt_nxt = inl_inc;
        end
        out_inl_nxt = inl_cnt_nxt;
        state_nxt   = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sweep_r     <= '0;
      ctr_cnt_r   <= '0;
      proj_cnt_r  <= '0;
      inl_cnt_r   <= '0;
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      width_r     <= 11'd640;
      height_r    <= 11'd480;
      radius_r    <= 12'd96;
      o2o_r       <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      ctr_cnt_r   <= ctr_cnt_nxt;
      proj_cnt_r  <= proj_cnt_nxt;
      inl_cnt_r   <= inl_cnt_nxt;
      s1_vld_r    <= s1_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_WIDTH:   width_r  <= cfg_data[10:0];
          CFG_HEIGHT:  height_r <= cfg_data[10:0];
          CFG_RADIUS:  radius_r <= cfg_data;
          CFG_ONE2ONE: o2o_r    <= cfg_data[0];
          default:     o2o_r    <= o2o_r;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    range_r     <= range_nxt;
    r2_r        <= r2_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    dy2_r       <= dy2_nxt;
    s1_addr_r   <= s1_addr_nxt;
    s1_d2_r     <= s1_d2_nxt;
    q_in_r      <= q_in_nxt;
    q_label_r   <= q_label_nxt;
    item_r      <= item_nxt;
    out_hit_r   <= out_hit_nxt;
    out_label_r <= out_label_nxt;
    out_item_r  <= out_item_nxt;
    out_inl_r   <= out_inl_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_label        = $signed(out_label_r);
  assign out_item_index   = out_item_r;
  assign out_inlier_count = out_inl_r;
  assign out_overflow     = out_ovf_r;

endmodule

[src/nclm_checker.sv]
// ----------------------------------------------------------------------------
// nclm_checker
// port-level checks on the label map block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nclm_checker import nclm_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic                      out_hit,
  input logic signed [LABEL_W-1:0] out_label,
  input logic                      out_overflow
);

  // an accepted transaction always occupies the block
  `NCLM_AST_NXT(a_accept_busy, start && !busy, busy)
  // a result follows work, and the block is free when it shows
  `NCLM_AST_IMP(a_result_after_work, out_valid, $past(busy) && !busy)
  // refused stamp carries no label and no hit
  `NCLM_AST_IMP(a_ovf_shape, out_valid && out_overflow, (out_label == -11'sd1) && !out_hit)
  // a hit always names a real label
  `NCLM_AST_IMP(a_hit_labeled, out_valid && out_hit, !out_label[LABEL_W-1] && !out_overflow)

endmodule

bind nearest_center_label_map_inliers nclm_checker u_nclm_checker (.*);
